### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the generator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge out of reset
`define MWC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Expression must never be true out of reset
`define MWC_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");

`else

`define MWC_ASSERT(lbl, clk, rstn, prop)
`define MWC_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

### hdl/mwc_pkg.sv
// ----------------------------------------------------------------------------
// mwc_pkg
// Opcodes, generator constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mwc_pkg;

    // Operation codes
    localparam logic [1:0] OP_SEED  = 2'd0;
    localparam logic [1:0] OP_NEXT  = 2'd1;
    localparam logic [1:0] OP_RANGE = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Generator weights and seeding multiplier
    localparam logic [31:0] MWC_M3    = 32'd2111111111;
    localparam logic [31:0] MWC_M2    = 32'd1492;
    localparam logic [31:0] MWC_M1    = 32'd1776;
    localparam logic [31:0] MWC_M0    = 32'd5115;
    localparam logic [31:0] SEED_MULT = 32'd29943829;
    localparam logic [31:0] RANGE_ERR = 32'h8000_0000;

    localparam int WARMUP_STEPS_DEF = 19;

    // Multiplier operand selection
    localparam logic [2:0] SEL_M3   = 3'd0;
    localparam logic [2:0] SEL_M2   = 3'd1;
    localparam logic [2:0] SEL_M1   = 3'd2;
    localparam logic [2:0] SEL_M0   = 3'd3;
    localparam logic [2:0] SEL_SEED = 3'd4;
    localparam logic [2:0] SEL_SPAN = 3'd5;

    // Controller to datapath commands
    typedef struct packed {
        logic       latch_in;
        logic       load_seed;
        logic       seed_zero;
        logic       mix;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       acc_init;
        logic       acc_add;
        logic       commit;
        logic       load_out;
    } mwc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       range_empty;
        logic       range_rev;
        logic       out_free;
    } mwc_stat_t;

endpackage

### hdl/multiply_with_carry_prng_core.sv
// ----------------------------------------------------------------------------
// multiply_with_carry_prng_core
// Multiply-with-carry random generator: seed, raw word and ranged integer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries opcode, seed_value, range_low
//   and range_high. Output channel (out_valid/out_ready) carries random_word,
//   ranged_value and range_error. A seed item and opcode 3 give no result.
// Sequence from accept to result register loaded:
//   next word        : decode, generator step, emit
//   ranged integer   : decode, generator step, span product, emit
//   empty/reversed   : decode, emit; no generator step
//   seed             : decode, load, seeding shifts, warm-up steps; no result
//   One item is in work at a time; no new item is accepted until the last
//   one is done. Each step is four products through a single shared 32x32
//   multiplier plus a commit.
// Reset: the controller seeds the generator with zero and runs the warm-up
//   with in_ready low.
// Stall: the result sits in an output register; the next item is accepted
//   while it waits, and that item's result is held back until the register
//   is taken.
// ----------------------------------------------------------------------------
module multiply_with_carry_prng_core
#(
    parameter int WARMUP_STEPS = mwc_pkg::WARMUP_STEPS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          opcode,
    input  logic signed [31:0]  seed_value,
    input  logic signed [31:0]  range_low,
    input  logic signed [31:0]  range_high,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         random_word,
    output logic signed [31:0]  ranged_value,
    output logic                range_error
);

    mwc_pkg::mwc_cmd_t  cmd;
    mwc_pkg::mwc_stat_t stat;

    // Sequencer
    mwc_ctrl #(
        .WARMUP_STEPS (WARMUP_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Datapath
    mwc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (opcode),
        .seed_value   (seed_value),
        .range_low    (range_low),
        .range_high   (range_high),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .random_word  (random_word),
        .ranged_value (ranged_value),
        .range_error  (range_error)
    );

endmodule

### hdl/mwc_dp.sv
// ----------------------------------------------------------------------------
// mwc_dp
// Generator state, shared 32x32 multiplier, 64-bit accumulator, output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mwc_dp
(
    input  logic                clk,
    input  logic                rst_n,
    input  mwc_pkg::mwc_cmd_t   cmd,
    output mwc_pkg::mwc_stat_t  stat,
    input  logic [1:0]          opcode,
    input  logic signed [31:0]  seed_value,
    input  logic signed [31:0]  range_low,
    input  logic signed [31:0]  range_high,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         random_word,
    output logic signed [31:0]  ranged_value,
    output logic                range_error
);

    // Latched item
    logic [1:0]  op_reg;
    logic [31:0] seed_reg;
    logic [31:0] lo_reg;
    logic [31:0] hi_reg;

    // Generator state
    logic [31:0] h0_reg, h1_reg, h2_reg, h3_reg, carry_reg;

    // Arithmetic
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_full;
    logic [63:0] sum;
    logic [31:0] span;
    logic [31:0] seed_next;

    // Output register
    logic        out_valid_reg;
    logic [31:0] word_reg;
    logic [31:0] ranged_reg;
    logic        err_reg;
    logic [31:0] word_next;
    logic [31:0] ranged_next;

    assign span      = hi_reg - lo_reg;
    assign sum       = acc_reg + prod_reg;
    assign seed_next = mul_full[31:0] - 32'd1;

    // Multiplier operand mux
    always_comb
    begin
        case (cmd.mul_sel)
            mwc_pkg::SEL_M3:   begin mul_a = h3_reg;    mul_b = mwc_pkg::MWC_M3;    end
            mwc_pkg::SEL_M2:   begin mul_a = h2_reg;    mul_b = mwc_pkg::MWC_M2;    end
            mwc_pkg::SEL_M1:   begin mul_a = h1_reg;    mul_b = mwc_pkg::MWC_M1;    end
            mwc_pkg::SEL_M0:   begin mul_a = h0_reg;    mul_b = mwc_pkg::MWC_M0;    end
            mwc_pkg::SEL_SEED: begin mul_a = carry_reg; mul_b = mwc_pkg::SEED_MULT; end
            mwc_pkg::SEL_SPAN: begin mul_a = span;      mul_b = h0_reg;             end
            default:           begin mul_a = '0;        mul_b = '0;                 end
        endcase
    end

    assign mul_full = {32'd0, mul_a} * {32'd0, mul_b};

    // Item capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg   <= opcode;
            seed_reg <= seed_value;
            lo_reg   <= range_low;
            hi_reg   <= range_high;
        end
    end

    // Product and accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= mul_full;
        if (cmd.acc_init)
            acc_reg <= {32'd0, carry_reg};
        else if (cmd.acc_add)
            acc_reg <= sum;
    end

    // Generator state: seed load, seeding shift, step commit
    always_ff @(posedge clk)
    begin
        if (cmd.load_seed)
        begin
            carry_reg <= cmd.seed_zero ? 32'd0 : seed_reg;
        end
        else if (cmd.mix)
        begin
            // after five shifts h0..h3, carry hold the five values in order
            h0_reg    <= h1_reg;
            h1_reg    <= h2_reg;
            h2_reg    <= h3_reg;
            h3_reg    <= carry_reg;
            carry_reg <= seed_next;
        end
        else if (cmd.commit)
        begin
            h3_reg    <= h2_reg;
            h2_reg    <= h1_reg;
            h1_reg    <= h0_reg;
            h0_reg    <= sum[31:0];
            carry_reg <= sum[63:32];
        end
    end

    // Result selection
    always_comb
    begin
        word_next   = 32'd0;
        ranged_next = 32'd0;
        if (op_reg == mwc_pkg::OP_NEXT)
        begin
            word_next = h0_reg;
        end
        else if (stat.range_rev)
        begin
            ranged_next = mwc_pkg::RANGE_ERR;
        end
        else if (stat.range_empty)
        begin
            ranged_next = lo_reg;
        end
        else
        begin
            word_next   = h0_reg;
            ranged_next = lo_reg + prod_reg[63:32];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            word_reg   <= word_next;
            ranged_reg <= ranged_next;
            err_reg    <= (op_reg == mwc_pkg::OP_RANGE) && stat.range_rev;
        end
    end

    assign stat.op          = op_reg;
    assign stat.range_empty = (hi_reg == lo_reg);
    assign stat.range_rev   = ($signed(hi_reg) < $signed(lo_reg));
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign random_word  = word_reg;
    assign ranged_value = ranged_reg;
    assign range_error  = err_reg;

    // Checks
    `MWC_ASSERT_NEVER(a_load_busy, clk, rst_n, cmd.load_out && out_valid_reg && !out_ready)
    `MWC_ASSERT_NEVER(a_mix_commit, clk, rst_n, cmd.mix && cmd.commit)
    `MWC_ASSERT(a_load_valid, clk, rst_n, cmd.load_out |=> out_valid_reg)

endmodule

### hdl/mwc_ctrl.sv
// ----------------------------------------------------------------------------
// mwc_ctrl
// Sequencer for seeding, warm-up, generator steps and result hand-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mwc_ctrl
#(
    parameter int WARMUP_STEPS = mwc_pkg::WARMUP_STEPS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output mwc_pkg::mwc_cmd_t   cmd,
    input  mwc_pkg::mwc_stat_t  stat
);

    localparam int WCW = $clog2(WARMUP_STEPS + 2);

    localparam logic [2:0] S_INIT      = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_DECODE    = 3'd2;
    localparam logic [2:0] S_SEED_LOAD = 3'd3;
    localparam logic [2:0] S_SEED_MIX  = 3'd4;
    localparam logic [2:0] S_STEP      = 3'd5;
    localparam logic [2:0] S_RANGE_MUL = 3'd6;
    localparam logic [2:0] S_EMIT      = 3'd7;

    localparam logic [2:0] LAST_PHASE = 3'd4;

    logic [2:0]     state_reg, state_next;
    logic [2:0]     phase_reg, phase_next;
    logic [WCW-1:0] warm_cnt_reg, warm_cnt_next;
    logic           warm_reg, warm_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            phase_reg    <= '0;
            warm_cnt_reg <= '0;
            warm_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            warm_cnt_reg <= warm_cnt_next;
            warm_reg     <= warm_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        warm_cnt_next = warm_cnt_reg;
        warm_next     = warm_reg;
        cmd           = '0;
        cmd.mul_sel   = mwc_pkg::SEL_M3;

        unique case (state_reg)
            S_INIT:
            begin
                // reset state is the generator seeded with zero
                cmd.load_seed = 1'b1;
                cmd.seed_zero = 1'b1;
                phase_next    = '0;
                state_next    = S_SEED_MIX;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                phase_next = '0;
                unique case (stat.op)
                    mwc_pkg::OP_SEED:  state_next = S_SEED_LOAD;
                    mwc_pkg::OP_NEXT:  state_next = S_STEP;
                    mwc_pkg::OP_RANGE:
                        state_next = (stat.range_empty || stat.range_rev) ? S_EMIT : S_STEP;
                    mwc_pkg::OP_NONE:  state_next = S_IDLE;
                endcase
            end
            S_SEED_LOAD:
            begin
                cmd.load_seed = 1'b1;
                phase_next    = '0;
                state_next    = S_SEED_MIX;
            end
            S_SEED_MIX:
            begin
                cmd.mix     = 1'b1;
                cmd.mul_sel = mwc_pkg::SEL_SEED;
                if (phase_reg == LAST_PHASE)
                begin
                    phase_next    = '0;
                    warm_cnt_next = WCW'(WARMUP_STEPS);
                    if (WARMUP_STEPS == 0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        warm_next  = 1'b1;
                        state_next = S_STEP;
                    end
                end
                else
                begin
                    phase_next = phase_reg + 3'd1;
                end
            end
            S_STEP:
            begin
                if (phase_reg == LAST_PHASE)
                begin
                    cmd.commit = 1'b1;
                    phase_next = '0;
                    if (warm_reg)
                    begin
                        if (warm_cnt_reg == WCW'(1))
                        begin
                            warm_next  = 1'b0;
                            state_next = S_IDLE;
                        end
                        warm_cnt_next = warm_cnt_reg - WCW'(1);
                    end
                    else if (stat.op == mwc_pkg::OP_RANGE)
                    begin
                        state_next = S_RANGE_MUL;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    // one weighted product per cycle, summed in the following cycle
                    cmd.mul_en   = 1'b1;
                    cmd.acc_init = (phase_reg == 3'd0);
                    cmd.acc_add  = (phase_reg != 3'd0);
                    case (phase_reg)
                        3'd0:    cmd.mul_sel = mwc_pkg::SEL_M3;
                        3'd1:    cmd.mul_sel = mwc_pkg::SEL_M2;
                        3'd2:    cmd.mul_sel = mwc_pkg::SEL_M1;
                        default: cmd.mul_sel = mwc_pkg::SEL_M0;
                    endcase
                    phase_next = phase_reg + 3'd1;
                end
            end
            S_RANGE_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = mwc_pkg::SEL_SPAN;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    // Checks
    `MWC_ASSERT(a_accept_decode, clk, rst_n, (in_valid && in_ready) |=> (state_reg == S_DECODE))
    `MWC_ASSERT_NEVER(a_phase_range, clk, rst_n, phase_reg > LAST_PHASE)
    `MWC_ASSERT_NEVER(a_warm_emit, clk, rst_n, warm_reg && cmd.load_out)

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the multiply-with-carry random generator core.
// A short table of directed items covers the field extremes, every opcode,
// empty and reversed ranges and the unused opcode. Random items follow in
// four handshake phases. Each result is checked against a hand-written row
// or a local model of the generator state: four history words and a carry.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WARMUP = mwc_pkg::WARMUP_STEPS_DEF;
    localparam int ITEMS_PER_PHASE = 180;

    // Short local names for the codes
    localparam logic [1:0]  OP_SEED   = mwc_pkg::OP_SEED;
    localparam logic [1:0]  OP_NEXT   = mwc_pkg::OP_NEXT;
    localparam logic [1:0]  OP_RANGE  = mwc_pkg::OP_RANGE;
    localparam logic [1:0]  OP_NONE   = mwc_pkg::OP_NONE;
    localparam logic [31:0] RANGE_ERR = mwc_pkg::RANGE_ERR;

    // One input item and one result item
    typedef struct {
        logic [1:0]  op;
        logic [31:0] seed;
        logic [31:0] lo;
        logic [31:0] hi;
    } item_t;

    typedef struct {
        logic [31:0] word;
        logic [31:0] ranged;
        logic        err;
    } result_t;

    // Directed row: item plus an optional hand-written expectation
    typedef struct {
        item_t       it;
        bit          fixed;
        result_t     res;
    } row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [1:0]          opcode = OP_NONE;
    logic signed [31:0]  seed_value = '0;
    logic signed [31:0]  range_low = '0;
    logic signed [31:0]  range_high = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [31:0]         random_word;
    logic signed [31:0]  ranged_value;
    logic                range_error;

    // Generator state as the block should hold it
    logic [31:0] gen_hist [4];
    logic [31:0] gen_carry;

    result_t pending_results [$];

    int mismatches = 0;
    int results_seen = 0;
    int n_seed = 0;
    int n_next = 0;
    int n_ranged = 0;
    int n_range_flat = 0;
    int n_range_err = 0;
    int n_ignored = 0;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_req = 0;

    multiply_with_carry_prng_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .seed_value   (seed_value),
        .range_low    (range_low),
        .range_high   (range_high),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .random_word  (random_word),
        .ranged_value (ranged_value),
        .range_error  (range_error)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Run limit, far above the slowest legal run
    initial
    begin
        #(40_000_000);
        $display("Timeout: %0d results still expected", pending_results.size());
        $display("Verification failed");
        $finish;
    end

    // One generator step: weighted sum of the history plus carry
    function automatic logic [31:0] mwc_advance();
        logic [63:0] acc;
        acc = 64'(mwc_pkg::MWC_M3) * 64'(gen_hist[3])
            + 64'(mwc_pkg::MWC_M2) * 64'(gen_hist[2])
            + 64'(mwc_pkg::MWC_M1) * 64'(gen_hist[1])
            + 64'(mwc_pkg::MWC_M0) * 64'(gen_hist[0])
            + 64'(gen_carry);
        gen_hist[3] = gen_hist[2];
        gen_hist[2] = gen_hist[1];
        gen_hist[1] = gen_hist[0];
        gen_hist[0] = acc[31:0];
        gen_carry   = acc[63:32];
        return acc[31:0];
    endfunction

    // Seeding: chain of s*mult-1 fills five words, then the warm-up steps
    function automatic void mwc_reseed(logic [31:0] seed);
        logic [31:0] s;
        s = seed;
        for (int i = 0; i < 4; i++)
        begin
            s = s * mwc_pkg::SEED_MULT - 32'd1;
            gen_hist[i] = s;
        end
        s = s * mwc_pkg::SEED_MULT - 32'd1;
        gen_carry = s;
        for (int i = 0; i < WARMUP; i++)
            void'(mwc_advance());
    endfunction

    // Expected result of one item; returns 0 when the item gives none
    function automatic bit mwc_predict(item_t it, output result_t r);
        logic [31:0] w;
        logic [31:0] span;
        logic [63:0] prod;
        r = '{word: '0, ranged: '0, err: 1'b0};
        case (it.op)
            OP_SEED:
            begin
                mwc_reseed(it.seed);
                n_seed++;
                return 1'b0;
            end
            OP_NEXT:
            begin
                r.word = mwc_advance();
                n_next++;
                return 1'b1;
            end
            OP_RANGE:
            begin
                if (it.hi == it.lo)
                begin
                    r.ranged = it.lo;
                    n_range_flat++;
                end
                else if ($signed(it.hi) < $signed(it.lo))
                begin
                    r.ranged = RANGE_ERR;
                    r.err = 1'b1;
                    n_range_err++;
                end
                else
                begin
                    w = mwc_advance();
                    span = it.hi - it.lo;
                    prod = 64'(span) * 64'(w);
                    r.word = w;
                    r.ranged = it.lo + prod[63:32];
                    n_ranged++;
                end
                return 1'b1;
            end
            default:
            begin
                n_ignored++;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // Offer one item, wait for the handshake and record what it should give
    task automatic send_item(item_t it, bit use_fixed = 1'b0, result_t fixed_res = '{0, 0, 0});
        result_t r;
        bit has_r;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct)
                @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= it.op;
        seed_value <= it.seed;
        range_low  <= it.lo;
        range_high <= it.hi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        has_r = mwc_predict(it, r);
        if (use_fixed)
            r = fixed_res;
        if (has_r)
            pending_results.push_back(r);
    endtask

    // Hold the input side quiet until every result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Random item: mostly real work, some seeds, a little unused opcode
    function automatic item_t make_random_item();
        item_t it;
        logic [31:0] tmp;
        int pick;
        it.seed = $urandom;
        it.lo   = $urandom;
        it.hi   = $urandom;
        pick = $urandom_range(99);
        if (pick < 8)
            it.op = OP_SEED;
        else if (pick < 44)
            it.op = OP_NEXT;
        else if (pick < 96)
        begin
            it.op = OP_RANGE;
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5:
                begin
                    if ($signed(it.hi) < $signed(it.lo))
                    begin
                        tmp = it.hi;
                        it.hi = it.lo;
                        it.lo = tmp;
                    end
                end
                6, 7: it.hi = it.lo + $urandom_range(1, 64);
                8:    it.hi = it.lo;
                default: ;
            endcase
        end
        else
            it.op = OP_NONE;
        return it;
    endfunction

    // Random phase: counts only items the block acts on
    task automatic run_phase(int idle_pct, int stall_pct, int hold_cycles);
        item_t it;
        int done;
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        hold_req     = hold_cycles;
        done = 0;
        while (done < ITEMS_PER_PHASE)
        begin
            it = make_random_item();
            send_item(it);
            if (it.op != OP_NONE)
                done++;
        end
        wait_drained();
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Result checker
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, random_word", random_word, '0);
            else
            begin
                want = pending_results.pop_front();
                if (random_word !== want.word)
                    report_mismatch("random_word", random_word, want.word);
                if (ranged_value !== want.ranged)
                    report_mismatch("ranged_value", ranged_value, want.ranged);
                if (range_error !== want.err)
                    report_mismatch("range_error", 32'(range_error), 32'(want.err));
            end
        end
    end

    // Main sequence
    initial
    begin
        row_t rows [$];

        mwc_reseed('0);

        // Directed table
        rows = '{
            '{'{OP_NEXT,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0, '{0, 0, 0}},
            '{'{OP_RANGE, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000}, 1'b1,
              '{32'h0, 32'h0, 1'b0}},
            '{'{OP_RANGE, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b0, '{0, 0, 0}},
            '{'{OP_RANGE, 32'h0000_0000, 32'h0000_0005, 32'h0000_0004}, 1'b1,
              '{32'h0, RANGE_ERR, 1'b1}},
            '{'{OP_RANGE, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b1,
              '{32'h0, RANGE_ERR, 1'b1}},
            '{'{OP_RANGE, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b1,
              '{32'h0, 32'h8000_0000, 1'b0}},
            '{'{OP_RANGE, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b1,
              '{32'h0, 32'h7FFF_FFFF, 1'b0}},
            '{'{OP_NONE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '{0, 0, 0}},
            '{'{OP_NEXT,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '{0, 0, 0}},
            '{'{OP_SEED,  32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b0, '{0, 0, 0}},
            '{'{OP_NEXT,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0, '{0, 0, 0}},
            '{'{OP_SEED,  32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000}, 1'b0, '{0, 0, 0}},
            '{'{OP_NEXT,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0, '{0, 0, 0}},
            '{'{OP_SEED,  32'h8000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0, '{0, 0, 0}},
            '{'{OP_RANGE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001}, 1'b0, '{0, 0, 0}},
            '{'{OP_SEED,  32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000}, 1'b0, '{0, 0, 0}},
            '{'{OP_RANGE, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b0, '{0, 0, 0}},
            '{'{OP_RANGE, 32'h0000_0000, 32'hFFFF_FF9C, 32'h0000_0064}, 1'b0, '{0, 0, 0}},
            '{'{OP_SEED,  32'h0000_3039, 32'h0000_0000, 32'h0000_0000}, 1'b0, '{0, 0, 0}},
            '{'{OP_NEXT,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0, '{0, 0, 0}},
            '{'{OP_RANGE, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF}, 1'b0, '{0, 0, 0}},
            '{'{OP_NONE,  32'h1234_5678, 32'h0000_0001, 32'h0000_0002}, 1'b0, '{0, 0, 0}},
            '{'{OP_NEXT,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0, '{0, 0, 0}}
        };

        // Reset, released on a clock edge
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
            send_item(rows[i].it, rows[i].fixed, rows[i].res);
        wait_drained();

        // No idling; the long hold-off fills the block while items keep coming
        run_phase(0, 0, 400);
        run_phase(64, 0, 0);
        run_phase(0, 64, 0);
        run_phase(20, 20, 0);

        // A seed could still be warming up; let it finish before the verdict
        repeat (200) @(posedge clk);

        $display("Covered %0d seeds, %0d raw words, %0d ranged values, %0d empty ranges,",
                 n_seed, n_next, n_ranged, n_range_flat);
        $display("%0d reversed ranges and %0d ignored items; %0d results checked, %0d mismatches",
                 n_range_err, n_ignored, results_seen, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
